/* rtl/tidlq_pkg.sv */
// types, codes and constants for the thread id linked queue
`default_nettype none

package tidlq_pkg;

  localparam int SLOT_W = 6;
  localparam int DEF_THREAD_SLOTS = 64;
  // slot numbers are 6 bits wide, so no more link entries than this are ever used
  localparam int MAX_LINKS = 1 << SLOT_W;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_PRESENT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_POP,
    FSM_WALK,
    FSM_UNLINK,
    FSM_RESP
  } fsm_e;

  typedef struct packed {
    action_e action;
    slot_t   thread_slot;
  } req_t;

  typedef struct packed {
    status_e status;
    slot_t   result_slot;
    slot_t   position;
  } rsp_t;

  // write and read port of the link table
  typedef struct packed {
    logic  we;
    slot_t waddr;
    slot_t wdata;
    slot_t raddr;
  } link_port_t;

endpackage

`default_nettype wire

/* rtl/tidlq_link_ram.sv */
// next-link table: one write port, one registered read port
`default_nettype none

module tidlq_link_ram
  import tidlq_pkg::*;
#(
  parameter int DEPTH = DEF_THREAD_SLOTS
) (
  input  wire logic       clk_i,
  input  wire link_port_t port_i,
  output slot_t           rdata_o
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  slot_t mem_q [DEPTH];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (port_i.we) begin
      mem_q[ADDR_W'(port_i.waddr)] <= port_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[ADDR_W'(port_i.raddr)];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/thread_id_linked_queue.sv */
// linked fifo of thread slots with pop, remove and membership query
//
//  channel  valid        stall        payload      direction
//  request  in_valid_i   in_stall_o   in_data_i    in  (action, thread_slot)
//  result   out_valid_o  out_stall_i  out_data_o   out (status, result_slot, position)
//
// one request at a time; a result per request, held in an output register
// insert, remove and query walk the link ram one entry per cycle from the head;
//   remove then unlinks the found slot in a state of its own;
//   a miss or an insert at the tail ends when the walk reaches the tail
// pop reads the new head from the link ram; requests that need no walk skip the walk
// after reset the list is empty; the link ram needs no clearing
// a stalled result stays in the output register while the next request walks
`default_nettype none

module thread_id_linked_queue
  import tidlq_pkg::*;
#(
  parameter int THREAD_SLOTS = DEF_THREAD_SLOTS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_data_o
);

  localparam int LINK_DEPTH = (THREAD_SLOTS < MAX_LINKS) ? THREAD_SLOTS : MAX_LINKS;

  fsm_e  state_q, state_d;
  slot_t head_q, head_d;
  slot_t tail_q, tail_d;
  logic  empty_q, empty_d;
  req_t  req_q, req_d;
  slot_t prev_q, prev_d;
  slot_t pos_q, pos_d;
  logic  first_q, first_d;
  rsp_t  res_q, res_d;
  logic  out_valid_q, out_valid_d;
  rsp_t  out_q, out_d;

  link_port_t link_port;
  slot_t      link_rdata;
  slot_t      cur;
  slot_t      pos_next;
  logic       slot_ok;

  tidlq_link_ram #(
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .port_i  (link_port),
    .rdata_o (link_rdata)
  );

  // first walk step looks at the head, later steps at the link just read
  assign cur      = first_q ? head_q : link_rdata;
  assign pos_next = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign slot_ok  = 32'(in_data_i.thread_slot) < THREAD_SLOTS;

  assign in_stall_o  = (state_q != FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    empty_d     = empty_q;
    req_d       = req_q;
    prev_d      = prev_q;
    pos_d       = pos_q;
    first_d     = first_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    link_port.we    = 1'b0;
    link_port.waddr = tail_q;
    link_port.wdata = req_q.thread_slot;
    link_port.raddr = (state_q == FSM_WALK) ? cur : head_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          first_d = 1'b1;
          pos_d   = '0;
          prev_d  = '0;
          if (in_data_i.action == ACT_POP) begin
            if (empty_q) begin
              res_d   = '{status: ST_EMPTY, result_slot: '0, position: '0};
              state_d = FSM_RESP;
            end else begin
              // read of link(head) is under way this cycle
              state_d = FSM_POP;
            end
          end else if (!slot_ok) begin
            res_d   = '{status: ST_ABSENT, result_slot: in_data_i.thread_slot, position: '0};
            state_d = FSM_RESP;
          end else if (empty_q) begin
            if (in_data_i.action == ACT_INSERT) begin
              head_d  = in_data_i.thread_slot;
              tail_d  = in_data_i.thread_slot;
              empty_d = 1'b0;
              res_d   = '{status: ST_OK, result_slot: in_data_i.thread_slot, position: '0};
            end else begin
              res_d   = '{status: ST_ABSENT, result_slot: in_data_i.thread_slot,
                          position: '0};
            end
            state_d = FSM_RESP;
          end else begin
            state_d = FSM_WALK;
          end
        end
      end

      FSM_POP: begin
        res_d = '{status: ST_OK, result_slot: head_q, position: '0};
        if (head_q == tail_q) begin
          empty_d = 1'b1;
        end else begin
          head_d = link_rdata;
        end
        state_d = FSM_RESP;
      end

      FSM_WALK: begin
        if (cur == req_q.thread_slot) begin
          state_d = FSM_RESP;
          unique case (req_q.action)
            ACT_INSERT: begin
              res_d = '{status: ST_PRESENT, result_slot: req_q.thread_slot, position: pos_q};
            end
            ACT_REMOVE: begin
              res_d   = '{status: ST_OK, result_slot: req_q.thread_slot, position: pos_q};
              // link of the hit slot arrives next cycle
              state_d = FSM_UNLINK;
            end
            default: begin
              res_d = '{status: ST_OK, result_slot: req_q.thread_slot, position: pos_q};
            end
          endcase
        end else if (cur == tail_q) begin
          state_d = FSM_RESP;
          if (req_q.action == ACT_INSERT) begin
            link_port.we = 1'b1;
            tail_d       = req_q.thread_slot;
            res_d        = '{status: ST_OK, result_slot: req_q.thread_slot,
                             position: pos_next};
          end else begin
            res_d = '{status: ST_ABSENT, result_slot: req_q.thread_slot, position: '0};
          end
        end else begin
          prev_d  = cur;
          pos_d   = pos_next;
          first_d = 1'b0;
        end
      end

      FSM_UNLINK: begin
        if (req_q.thread_slot == head_q) begin
          if (head_q == tail_q) begin
            empty_d = 1'b1;
          end else begin
            head_d = link_rdata;
          end
        end else begin
          link_port.we    = 1'b1;
          link_port.waddr = prev_q;
          link_port.wdata = link_rdata;
          if (req_q.thread_slot == tail_q) begin
            tail_d = prev_q;
          end
        end
        state_d = FSM_RESP;
      end

      FSM_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    prev_q  <= prev_d;
    pos_q   <= pos_d;
    first_q <= first_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // a new result only ever comes out of the response state
  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == FSM_RESP)
    else $error("result appeared outside the response state");

  // list pointers only move while a request is being worked on
  a_list_quiet_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_IDLE && !in_valid_i) |=>
      ($stable(head_q) && $stable(tail_q) && $stable(empty_q)))
    else $error("list changed with no request in flight");

  // walks, pops and unlinks only run over a list that holds something
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_WALK || state_q == FSM_UNLINK || state_q == FSM_POP) |-> !empty_q)
    else $error("walk over an empty list");

  // a waiting result is not overwritten
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result lost");

endmodule

`default_nettype wire
